// File: rtl/periodic_task_timing_monitor_core_assert.svh
// assertion macros for the periodic task timing monitor
`ifndef PERIODIC_TASK_TIMING_MONITOR_CORE_ASSERT_SVH
`define PERIODIC_TASK_TIMING_MONITOR_CORE_ASSERT_SVH

// same-cycle implication
`define PTTM_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("pttm assertion failed");

// next-cycle implication
`define PTTM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("pttm assertion failed");

`endif

// File: rtl/pttm_pkg.sv
// shared types and constants of the periodic task timing monitor
package pttm_pkg;

    localparam int unsigned TICK_W     = 32;
    localparam int unsigned RATE_W     = 17;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned TICKS_W    = 24;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned OUT_W      = 200;
    localparam int unsigned US_MULT_W  = 20;

    localparam int unsigned MS_PER_S   = 1000;
    localparam int unsigned US_PER_S   = 1000000;

    localparam int unsigned DIVA_DW    = 33;
    localparam int unsigned DIVA_VW    = TICKS_W;
    localparam int unsigned DIVB_DW    = TICK_W + US_MULT_W;
    localparam int unsigned DIVB_VW    = RATE_W;

    localparam int unsigned TICK_RATE_RST = 60;
    localparam int unsigned PERIOD_RST    = 100;
    localparam int unsigned DEADLINE_RST  = 100;
    localparam int unsigned P_RAW_RST     = (TICK_RATE_RST * PERIOD_RST) / MS_PER_S;
    localparam int unsigned P_RST         = (P_RAW_RST == 0) ? 1 : P_RAW_RST;
    localparam int unsigned D_RST         = (TICK_RATE_RST * DEADLINE_RST) / MS_PER_S;

    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESUME = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/periodic_task_timing_monitor_core.sv
// top level of the periodic task timing monitor
//
// channel   | direction | handshake              | contents
// s_axis    | in        | tvalid/tready          | tdata now_tick, tuser kind
// m_axis    | out       | tvalid/tready          | tdata result fields
// cfg       | in        | i_cfg_we, no wait      | i_cfg_idx, i_cfg_data
//
// first activation and resume go straight to the result state; a deadline check that
// finds a miss runs a 33-step serial divide by the period; a cycle end runs the 52-step
// serial divide of the run time by the tick rate
// a register write recomputes period and deadline ticks with two 33-step
// divides by 1000, during which no item is taken
// reset is synchronous; one result register decouples a stalled output
`include "periodic_task_timing_monitor_core_assert.svh"

module periodic_task_timing_monitor_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pttm_pkg::TICK_W-1:0]        s_axis_tdata,   // now_tick
    input  logic [pttm_pkg::KIND_W-1:0]        s_axis_tuser,   // kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // missed, miss_total, wake_delay, release_tick, run_time_us,
    // worst_run_us, start_delay, zero pad
    output logic [pttm_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [pttm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pttm_pkg::RATE_W-1:0]        i_cfg_data
);
    import pttm_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P_GO   = 4'd1;
    localparam logic [3:0] S_P_RUN  = 4'd2;
    localparam logic [3:0] S_D_GO   = 4'd3;
    localparam logic [3:0] S_D_RUN  = 4'd4;
    localparam logic [3:0] S_K1_CHK = 4'd5;
    localparam logic [3:0] S_K1_RUN = 4'd6;
    localparam logic [3:0] S_K2_SUB = 4'd7;
    localparam logic [3:0] S_K2_MUL = 4'd8;
    localparam logic [3:0] S_K2_GO  = 4'd9;
    localparam logic [3:0] S_K2_RUN = 4'd10;
    localparam logic [3:0] S_K2_NA  = 4'd11;
    localparam logic [3:0] S_K2_FIN = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    localparam int unsigned PAD_W = OUT_W - 1 - 6 * TICK_W;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic               r_dirty;
    logic               r_out_valid;

    logic [RATE_W-1:0]  r_rate;
    logic [MS_W-1:0]    r_per;
    logic [MS_W-1:0]    r_dl;
    logic [TICKS_W-1:0] r_p;
    logic [TICKS_W-1:0] r_d;

    logic [TICK_W-1:0]  r_release;
    logic [TICK_W-1:0]  r_next;
    logic [TICK_W-1:0]  r_abs;
    logic [TICK_W-1:0]  r_start;
    logic [TICK_W-1:0]  r_miss;
    logic [TICK_W-1:0]  r_worst;

    logic [TICK_W-1:0]  r_now;
    logic [DIVB_DW-1:0] r_prod;
    logic [TICK_W-1:0]  r_et;
    logic [TICK_W-1:0]  r_na;
    logic               r_ovr;
    logic               r_res_missed;
    logic [TICK_W-1:0]  r_res_wake;
    logic [TICK_W-1:0]  r_res_rel;
    logic [TICK_W-1:0]  r_res_run;
    logic [TICK_W-1:0]  r_res_sdelay;
    logic [OUT_W-1:0]   r_out_data;

    logic               w_acc;
    logic               w_first;
    logic [TICK_W-1:0]  w_p_ext;
    logic               w_out_load;
    logic [TICK_W-1:0]  w_dm1;
    logic               w_k1_hit;
    logic [TICK_W-1:0]  w_dk2;
    logic [RATE_W-1:0]  w_rate_div;

    logic               w_a_start;
    logic [DIVA_DW-1:0] w_a_dividend;
    logic [DIVA_VW-1:0] w_a_divisor;
    t_div_stat          w_a_stat;
    logic [DIVA_DW-1:0] w_a_quot;
    logic [DIVA_VW-1:0] w_a_rem;

    logic               w_b_start;
    t_div_stat          w_b_stat;
    logic [DIVB_DW-1:0] w_b_quot;
    logic [DIVB_VW-1:0] w_b_rem;

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE) && !r_dirty;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_first       = w_acc && (s_axis_tuser == KIND_FIRST);
    assign w_p_ext       = {{(TICK_W-TICKS_W){1'b0}}, r_p};
    assign w_out_load    = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // d - 1 for the deadline check, one adder
    assign w_dm1      = r_now + ~r_abs;
    assign w_k1_hit   = !w_dm1[TICK_W-1] && (w_dm1 != {1'b0, {(TICK_W-1){1'b1}}});
    assign w_dk2      = r_now - r_next;
    assign w_rate_div = (r_rate == '0) ? RATE_W'(1) : r_rate;

    assign w_a_start = (r_state == S_P_GO) || (r_state == S_D_GO) ||
                       ((r_state == S_K1_CHK) && w_k1_hit) || (r_state == S_K2_SUB);
    assign w_b_start = (r_state == S_K2_GO);

    always_comb begin
        w_a_dividend = r_prod[DIVA_DW-1:0];
        w_a_divisor  = r_p;
        if (r_state == S_K1_CHK) begin
            w_a_dividend = {1'b0, w_dm1};
        end else if (r_state == S_K2_SUB) begin
            w_a_dividend = {1'b0, w_dk2};
        end else if ((r_state == S_P_GO) || (r_state == S_D_GO)) begin
            w_a_divisor = DIVA_VW'(MS_PER_S);
        end
    end

    pttm_serial_div #(
        .DW (DIVA_DW),
        .VW (DIVA_VW)
    ) u_div_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_a_start),
        .i_dividend  (w_a_dividend),
        .i_divisor   (w_a_divisor),
        .o_stat      (w_a_stat),
        .o_quotient  (w_a_quot),
        .o_remainder (w_a_rem)
    );

    pttm_serial_div #(
        .DW (DIVB_DW),
        .VW (DIVB_VW)
    ) u_div_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_b_start),
        .i_dividend  (r_prod),
        .i_divisor   (w_rate_div),
        .o_stat      (w_b_stat),
        .o_quotient  (w_b_quot),
        .o_remainder (w_b_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    n_state = S_P_GO;
                end else if (w_acc) begin
                    unique case (s_axis_tuser)
                        KIND_CHECK: n_state = S_K1_CHK;
                        KIND_END:   n_state = S_K2_SUB;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_P_GO:   n_state = S_P_RUN;
            S_P_RUN:  if (w_a_stat.done) n_state = S_D_GO;
            S_D_GO:   n_state = S_D_RUN;
            S_D_RUN:  if (w_a_stat.done) n_state = S_IDLE;
            S_K1_CHK: n_state = w_k1_hit ? S_K1_RUN : S_OUT;
            S_K1_RUN: if (w_a_stat.done) n_state = S_OUT;
            S_K2_SUB: n_state = S_K2_MUL;
            S_K2_MUL: n_state = S_K2_GO;
            S_K2_GO:  n_state = S_K2_RUN;
            S_K2_RUN: if (!w_a_stat.busy && !w_b_stat.busy) n_state = S_K2_NA;
            S_K2_NA:  n_state = S_K2_FIN;
            S_K2_FIN: n_state = S_OUT;
            S_OUT:    if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control, configuration and task state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rate      <= RATE_W'(TICK_RATE_RST);
            r_per       <= MS_W'(PERIOD_RST);
            r_dl        <= MS_W'(DEADLINE_RST);
            r_p         <= TICKS_W'(P_RST);
            r_d         <= TICKS_W'(D_RST);
            r_release   <= '0;
            r_next      <= '0;
            r_abs       <= '0;
            r_start     <= '0;
            r_miss      <= '0;
            r_worst     <= '0;
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if ((r_state == S_IDLE) && r_dirty) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TICK_RATE: begin
                        r_rate  <= i_cfg_data;
                        r_dirty <= 1'b1;
                    end
                    CFG_PERIOD: begin
                        r_per   <= i_cfg_data[MS_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    CFG_DEADLINE: begin
                        r_dl    <= i_cfg_data[MS_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if ((r_state == S_P_RUN) && w_a_stat.done) begin
                r_p <= (w_a_quot == '0) ? TICKS_W'(1) : w_a_quot[TICKS_W-1:0];
            end
            if ((r_state == S_D_RUN) && w_a_stat.done) begin
                r_d <= w_a_quot[TICKS_W-1:0];
            end

            if (w_first) begin
                r_release <= s_axis_tdata;
                r_start   <= s_axis_tdata;
                r_abs     <= s_axis_tdata + {{(TICK_W-TICKS_W){1'b0}}, r_d};
                r_next    <= s_axis_tdata + w_p_ext;
            end
            if (w_acc && (s_axis_tuser == KIND_RESUME)) begin
                r_start <= s_axis_tdata;
            end

            if ((r_state == S_K1_RUN) && w_a_stat.done) begin
                r_miss <= r_miss + w_a_quot[TICK_W-1:0] + 1'b1;
            end

            if (r_state == S_K2_FIN) begin
                r_release <= r_na;
                r_abs     <= r_na + {{(TICK_W-TICKS_W){1'b0}}, r_d};
                r_next    <= r_na + w_p_ext;
                if (r_res_run > r_worst) begin
                    r_worst <= r_res_run;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && r_dirty) begin
            r_prod <= DIVB_DW'(r_rate) * DIVB_DW'(r_per);
        end else if ((r_state == S_P_RUN) && w_a_stat.done) begin
            r_prod <= DIVB_DW'(r_rate) * DIVB_DW'(r_dl);
        end else if (r_state == S_K2_MUL) begin
            r_prod <= r_et * US_MULT_W'(US_PER_S);
        end

        if (w_acc) begin
            r_now        <= s_axis_tdata;
            r_res_missed <= 1'b0;
            r_res_wake   <= '0;
            r_res_rel    <= '0;
            r_res_run    <= '0;
            r_res_sdelay <= (s_axis_tuser == KIND_RESUME) ? s_axis_tdata - r_release : '0;
        end

        if ((r_state == S_K1_RUN) && w_a_stat.done) begin
            r_res_missed <= 1'b1;
        end

        if (r_state == S_K2_SUB) begin
            r_et  <= r_now - r_start;
            r_ovr <= !w_dk2[TICK_W-1];
        end

        if ((r_state == S_K2_RUN) && !w_a_stat.busy && !w_b_stat.busy) begin
            r_na      <= r_ovr ? r_now - {{(TICK_W-TICKS_W){1'b0}}, w_a_rem} : r_next;
            r_res_run <= (|w_b_quot[DIVB_DW-1:TICK_W]) ? '1 : w_b_quot[TICK_W-1:0];
        end
        if (r_state == S_K2_NA) begin
            if (r_ovr) begin
                r_na <= r_na + w_p_ext;
            end
        end
        if (r_state == S_K2_FIN) begin
            r_res_wake <= r_na - r_now;
            r_res_rel  <= r_na;
        end

        if (w_out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, r_res_sdelay, r_worst, r_res_run, r_res_rel,
                           r_res_wake, r_miss, r_res_missed};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a first activation places the next release one period after the release
    `PTTM_ASSERT_NEXT(a_first_period, w_first, (r_next - r_release) == w_p_ext)
    // the miss count moves only when a deadline check divide completes
    `PTTM_ASSERT_NEXT(a_miss_hold, r_state != S_K1_RUN, $stable(r_miss))
    // a new result appears only out of the result state
    `PTTM_ASSERT_SAME(a_out_source, $rose(r_out_valid), $past(r_state) == S_OUT)

endmodule

// File: rtl/pttm_serial_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module pttm_serial_div #(
    parameter int unsigned DW = pttm_pkg::DIVA_DW,
    parameter int unsigned VW = pttm_pkg::DIVA_VW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [VW-1:0]       i_divisor,
    output pttm_pkg::t_div_stat o_stat,
    output logic [DW-1:0]       o_quotient,
    output logic [VW-1:0]       o_remainder
);
    import pttm_pkg::*;

    localparam int unsigned CW = $clog2(DW + 1);

    logic [DW-1:0] r_num;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   w_trial;
    logic [VW+1:0] w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_num[DW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_ge    = ~w_diff[VW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    t_div_stat w_stat;
    always_comb begin
        w_stat      = '0;
        w_stat.busy = r_busy;
        w_stat.done = r_done;
    end

    assign o_stat      = w_stat;
    assign o_quotient  = r_num;
    assign o_remainder = r_rem;

endmodule

// File: tb/periodic_task_timing_monitor_checker.sv
// checker for the periodic task timing monitor: predicts each report and compares it on the output
`timescale 1ns / 100ps

module periodic_task_timing_monitor_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [pttm_pkg::TICK_W-1:0]    i_in_tick,
    input  logic [pttm_pkg::KIND_W-1:0]    i_in_kind,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [pttm_pkg::OUT_W-1:0]     i_out_data,
    input  logic                           i_cfg_we,
    input  logic [pttm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pttm_pkg::RATE_W-1:0]    i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_reports,
    output int                             o_miss_flags
);
    import pttm_pkg::*;

    localparam int NFIELDS = 7;

    // field 0 missed, then miss_total, wake_delay, release_tick, run_time_us,
    // worst_run_us, start_delay
    typedef logic [NFIELDS-1:0][TICK_W-1:0] t_report;

    logic [RATE_W-1:0] cfg_rate     = RATE_W'(TICK_RATE_RST);
    logic [MS_W-1:0]   cfg_period   = MS_W'(PERIOD_RST);
    logic [MS_W-1:0]   cfg_deadline = MS_W'(DEADLINE_RST);

    logic [TICK_W-1:0] rel_time;
    logic [TICK_W-1:0] next_act;
    logic [TICK_W-1:0] abs_dl;
    logic [TICK_W-1:0] start_t;
    logic [TICK_W-1:0] miss_cnt;
    logic [TICK_W-1:0] worst_us;

    t_report expected_reports[$];
    int      mismatches = 0;
    int      reports    = 0;
    int      miss_flags = 0;

    function automatic string field_name(input int k);
        case (k)
            0:       return "missed";
            1:       return "miss_total";
            2:       return "wake_delay";
            3:       return "release_tick";
            4:       return "run_time_us";
            5:       return "worst_run_us";
            default: return "start_delay";
        endcase
    endfunction

    function automatic t_report unpack_report(input logic [OUT_W-1:0] d);
        t_report r;
        r    = '0;
        r[0] = {{(TICK_W-1){1'b0}}, d[0]};
        for (int k = 1; k < NFIELDS; k++) begin
            r[k] = d[1 + TICK_W * (k - 1) +: TICK_W];
        end
        return r;
    endfunction

    function automatic t_report monitor_step(input logic [KIND_W-1:0] kind,
                                             input logic [TICK_W-1:0] now);
        logic [63:0]       wide;
        logic [63:0]       stride;
        logic [63:0]       us;
        logic [TICK_W-1:0] p;
        logic [TICK_W-1:0] dl;
        logic [TICK_W-1:0] d;
        logic [TICK_W-1:0] na;
        logic [TICK_W-1:0] et;
        logic [TICK_W-1:0] rate;
        t_report           r;
        r    = '0;
        wide = 64'(cfg_rate) * 64'(cfg_period) / 64'(MS_PER_S);
        p    = wide[TICK_W-1:0];
        if (p == 0) begin
            p = 1;
        end
        wide = 64'(cfg_rate) * 64'(cfg_deadline) / 64'(MS_PER_S);
        dl   = wide[TICK_W-1:0];
        case (kind)
            KIND_FIRST: begin
                rel_time = now;
                start_t  = now;
                abs_dl   = now + dl;
                next_act = now + p;
            end
            KIND_CHECK: begin
                d = now - abs_dl;
                if (d != 0 && !d[TICK_W-1]) begin
                    miss_cnt = miss_cnt + (d - 1) / p + 1;
                    r[0]     = 1;
                end
            end
            KIND_END: begin
                na = next_act;
                d  = now - na;
                // at or past the next activation: skip the overrun periods
                if (!d[TICK_W-1]) begin
                    stride = (64'(d / p) + 64'd1) * 64'(p);
                    na     = na + stride[TICK_W-1:0];
                end
                r[2] = na - now;
                r[3] = na;
                et   = now - start_t;
                rate = (cfg_rate == 0) ? 1 : TICK_W'(cfg_rate);
                us   = 64'(et) * 64'(US_PER_S) / 64'(rate);
                r[4] = (us > 64'hFFFF_FFFF) ? '1 : us[TICK_W-1:0];
                if (r[4] > worst_us) begin
                    worst_us = r[4];
                end
                rel_time = na;
                abs_dl   = na + dl;
                next_act = na + p;
            end
            default: begin
                start_t = now;
                r[6]    = now - rel_time;
            end
        endcase
        r[1] = miss_cnt;
        r[5] = worst_us;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            cfg_rate     = RATE_W'(TICK_RATE_RST);
            cfg_period   = MS_W'(PERIOD_RST);
            cfg_deadline = MS_W'(DEADLINE_RST);
            rel_time     = '0;
            next_act     = '0;
            abs_dl       = '0;
            start_t      = '0;
            miss_cnt     = '0;
            worst_us     = '0;
            expected_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = unpack_report(i_out_data);
                reports++;
                if (expected_reports.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("report %0d arrived with none expected: %h", reports, got);
                    end
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    for (int k = 0; k < NFIELDS; k++) begin
                        if (got[k] !== want[k]) begin
                            if (mismatches < 10) begin
                                $display("report %0d %s: expected %h, got %h",
                                         reports, field_name(k), want[k], got[k]);
                            end
                            mismatches++;
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = monitor_step(i_in_kind, i_in_tick);
                if (want[0][0]) begin
                    miss_flags++;
                end
                expected_reports.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TICK_RATE: cfg_rate     = i_cfg_data;
                    CFG_PERIOD:    cfg_period   = i_cfg_data[MS_W-1:0];
                    CFG_DEADLINE:  cfg_deadline = i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_reports.size();
        o_reports    <= reports;
        o_miss_flags <= miss_flags;
    end

endmodule

// File: tb/periodic_task_timing_monitor_core_tb.sv
// testbench top for the periodic task timing monitor: stimulus, idling and verdict
`timescale 1ns / 100ps

module periodic_task_timing_monitor_core_tb;
    import pttm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NPHASES     = 12;
    localparam int PHASE_ITEMS = 120;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TICK_W-1:0]    s_axis_tdata  = '0;   // now_tick
    logic [KIND_W-1:0]    s_axis_tuser  = '0;   // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // missed, miss_total, wake_delay, release_tick, run_time_us,
    // worst_run_us, start_delay, zero pad
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [RATE_W-1:0]    i_cfg_data    = '0;

    int mismatches;
    int pending;
    int reports;
    int miss_flags;

    logic [RATE_W-1:0] cfg_rate     = RATE_W'(TICK_RATE_RST);
    logic [MS_W-1:0]   cfg_period   = MS_W'(PERIOD_RST);
    logic [MS_W-1:0]   cfg_deadline = MS_W'(DEADLINE_RST);
    logic [TICK_W-1:0] p_est        = TICK_W'(P_RST);
    logic [TICK_W-1:0] dl_est       = TICK_W'(D_RST);

    bit idle_on    = 1'b1;
    int stall_left = 0;
    int items_sent = 0;
    int settings   = 1;

    periodic_task_timing_monitor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    periodic_task_timing_monitor_checker monitor_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_tick    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_reports    (reports),
        .o_miss_flags (miss_flags)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d reports outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // output stalls in random bursts while idling is on
    always @(posedge i_clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [TICK_W-1:0] ms_ticks(input logic [MS_W-1:0] ms);
        logic [63:0] t;
        t = 64'(cfg_rate) * 64'(ms) / 64'(MS_PER_S);
        return t[TICK_W-1:0];
    endfunction

    // a tick close to a mark, now and then far from it
    function automatic logic [TICK_W-1:0] near(input logic [TICK_W-1:0] mark);
        logic [TICK_W-1:0] span;
        span = p_est / 4 + 3;
        case ($urandom_range(0, 9)) inside
            [0:4]:   return mark + $urandom_range(0, 2 * span) - span;
            [5:6]:   return mark + $urandom_range(0, 4) - 2;
            7:       return mark + p_est * $urandom_range(0, 5);
            8:       return mark - p_est * $urandom_range(1, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TICK_W-1:0] tick);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tick;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TICK_RATE: cfg_rate     = value;
            CFG_PERIOD:    cfg_period   = value[MS_W-1:0];
            CFG_DEADLINE:  cfg_deadline = value[MS_W-1:0];
            default: ;
        endcase
        p_est  = ms_ticks(cfg_period);
        dl_est = ms_ticks(cfg_deadline);
        if (p_est == 0) begin
            p_est = 1;
        end
    endtask

    task automatic set_config(input logic [RATE_W-1:0] rate, input logic [MS_W-1:0] period,
                              input logic [MS_W-1:0] deadline);
        write_reg(CFG_TICK_RATE, rate);
        write_reg(CFG_PERIOD, RATE_W'(period));
        write_reg(CFG_DEADLINE, RATE_W'(deadline));
        settings++;
    endtask

    // first activation followed by a few resume / check / end cycles
    task automatic run_task_cycles();
        logic [TICK_W-1:0] t;
        logic [TICK_W-1:0] end_t;
        if ($urandom_range(0, 3) == 0) begin
            t = 32'hFFFF_FFFF - $urandom_range(0, 3 * p_est);
        end else begin
            t = $urandom;
        end
        send_item(KIND_FIRST, t);
        repeat ($urandom_range(1, 6)) begin
            send_item(KIND_RESUME, t + $urandom_range(0, p_est / 8 + 2));
            if ($urandom_range(0, 1) == 0) begin
                send_item(KIND_CHECK, near(t + dl_est));
            end
            end_t = near(t + $urandom_range(0, p_est));
            send_item(KIND_END, end_t);
            if ($signed(end_t - (t + p_est)) < 0) begin
                t = t + p_est;
            end else begin
                t = end_t + $urandom_range(1, p_est);
            end
            if ($urandom_range(0, 3) == 0) begin
                send_item(KIND_CHECK, near(t + dl_est));
            end
        end
    endtask

    initial begin : stimulus
        int phase_start;
        logic [TICK_W-1:0] t;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unused register index must change nothing
        write_reg(CFG_UNUSED, '1);

        // directed part at the reset setting: period and deadline of 6 ticks
        send_item(KIND_RESUME, 32'h10);
        send_item(KIND_CHECK, 32'd0);
        send_item(KIND_FIRST, 32'd100);
        send_item(KIND_CHECK, 32'd106);
        send_item(KIND_CHECK, 32'd107);
        send_item(KIND_CHECK, 32'd124);
        send_item(KIND_CHECK, 32'd125);
        send_item(KIND_CHECK, 32'd106 + 32'h7FFF_FFFF);
        send_item(KIND_CHECK, 32'd106 + 32'h8000_0000);
        send_item(KIND_RESUME, 32'd101);
        send_item(KIND_END, 32'd104);
        send_item(KIND_RESUME, 32'd108);
        send_item(KIND_END, 32'd112);
        send_item(KIND_END, 32'hFFFF_FFFF);
        send_item(KIND_FIRST, 32'hFFFF_FFFC);
        send_item(KIND_RESUME, 32'hFFFF_FFFE);
        send_item(KIND_CHECK, 32'd3);
        send_item(KIND_END, 32'd1);
        send_item(KIND_END, 32'h8000_0000);
        send_item(KIND_FIRST, 32'd0);
        send_item(KIND_END, 32'd0);

        for (int ph = 0; ph < NPHASES; ph++) begin
            case (ph)
                0: set_config('0, '0, '0);
                1: set_config('1, '1, '1);
                2: set_config(17'd1, 16'd1, 16'd1);
                3: set_config(17'd100000, 16'd65535, 16'd1);
                4: set_config(17'd1000, 16'd1, 16'd65535);
                default: begin
                    set_config(RATE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 200)
                                                                   : $urandom_range(1, 100000)),
                               MS_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 200)
                                                                 : $urandom_range(1, 65535)),
                               MS_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 400)
                                                                 : $urandom_range(1, 65535)));
                end
            endcase
            idle_on = (ph == NPHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    8: begin
                        repeat ($urandom_range(1, 4)) begin
                            send_item(KIND_W'($urandom_range(0, 3)), $urandom);
                        end
                    end
                    9: begin
                        t = $urandom;
                        repeat ($urandom_range(2, 6)) begin
                            send_item(KIND_W'($urandom_range(0, 3)), near(t));
                            t = t + p_est / 2;
                        end
                    end
                    default: run_task_cycles();
                endcase
            end
        end

        drain();
        $display("%0d items over %0d register settings, %0d reports checked, %0d with misses",
                 items_sent, settings, reports, miss_flags);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
